>>> rtl/trz_pkg.sv
`timescale 1ns / 1ps
package trz_pkg;

	// screen and store geometry
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int XS_W       = $clog2(MAX_WIDTH);
	localparam int YS_W       = $clog2(MAX_HEIGHT);
	localparam int CFG_W      = 7;

	// fixed field widths
	localparam int DEPTH_W = 24;
	localparam int COLOR_W = 24;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;

	// arithmetic widths: screen coordinate, edge weight, dividend, divisor
	localparam int SC_W  = 10;
	localparam int EW    = 24;
	localparam int NUM_W = 48;
	localparam int DEN_W = 20;
	localparam int CNT_W = $clog2(NUM_W);

	// operation codes
	localparam logic [1:0] OP_VERTEX = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// register indexes
	localparam logic CFG_WIDTH_IDX  = 1'b0;
	localparam logic CFG_HEIGHT_IDX = 1'b1;

	typedef struct packed {
		logic [1:0]          operation;
		logic signed [15:0]  vertex_x;
		logic signed [15:0]  vertex_y;
		logic signed [23:0]  vertex_depth;
		logic [7:0]          vertex_red;
		logic [7:0]          vertex_green;
		logic [7:0]          vertex_blue;
		logic [11:0]         pixel_index;
	} in_t;

	typedef struct packed {
		logic [23:0]         pixel_color;
		logic signed [23:0]  pixel_depth;
	} out_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/trz_div.sv
`timescale 1ns / 1ps
module trz_div (
	input  logic              clk,
	input  logic              arst_n,
	input  trz_pkg::div_req_t req,
	output trz_pkg::div_rsp_t rsp
);
	import trz_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   mag_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic               done_q;
	logic signed [NUM_W-1:0] quo_q;

	logic [DEN_W:0]     shifted;
	logic               ge;
	logic [DEN_W:0]     diff;
	logic [NUM_W-1:0]   q_next;

	// one quotient bit per cycle, restoring
	always_comb begin
		shifted = {rem_q, mag_q[NUM_W-1]};
		ge      = (shifted >= {1'b0, den_q});
		diff    = shifted - {1'b0, den_q};
		q_next  = {mag_q[NUM_W-2:0], ge};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
			neg_q <= req.num[NUM_W-1];
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			mag_q <= q_next;
			if (cnt_q == CNT_W'(NUM_W - 1))
				quo_q <= neg_q ? -$signed(q_next) : $signed(q_next);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/triangle_raster_zbuffer_unit.sv
`timescale 1ns / 1ps
// read request: the read registers capture the stores at acceptance, S_READ loads the result
//   register once free; clear sweeps the depth store; triangle: S_MAP and S_SETUP, then
//   each box pixel: edge test, depth divide if inside, three more if it passes; shared divider
// one request at a time; a waiting result stalls only a following read
// reset: a pass over all 4096 addresses fills the depth store with maximum depth and the color store
//   with zero before the first request is accepted
module triangle_raster_zbuffer_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  trz_pkg::in_t             in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output trz_pkg::out_t            out_data,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [trz_pkg::CFG_W-1:0] cfg_data
);
	import trz_pkg::*;

	typedef enum logic [12:0] {
		S_INIT  = 13'h0001,
		S_IDLE  = 13'h0002,
		S_CLEAR = 13'h0004,
		S_READ  = 13'h0008,
		S_MAP   = 13'h0010,
		S_SETUP = 13'h0020,
		S_EDGE  = 13'h0040,
		S_TEST  = 13'h0080,
		S_MAC   = 13'h0100,
		S_DIV   = 13'h0200,
		S_CMP   = 13'h0400,
		S_WRITE = 13'h0800,
		S_NEXT  = 13'h1000
	} state_t;

	state_t state_q;

	// stores
	logic signed [DEPTH_W-1:0] depth_mem [STORE_SIZE];
	logic [COLOR_W-1:0]        color_mem [STORE_SIZE];
	logic signed [DEPTH_W-1:0] depth_rd_q;
	logic [COLOR_W-1:0]        color_rd_q;

	logic [CFG_W-1:0] w_raw_q, h_raw_q;
	logic [CFG_W-1:0] w_eff, h_eff;

	logic [1:0]  vcount_q;
	logic signed [15:0] vx_q [3];
	logic signed [15:0] vy_q [3];
	logic signed [23:0] vz_q [3];
	logic [7:0]  vr_q [3];
	logic [7:0]  vg_q [3];
	logic [7:0]  vb_q [3];
	logic signed [SC_W-1:0] sx_q [3];
	logic signed [SC_W-1:0] sy_q [3];

	logic [DEN_W-1:0] den_q;
	logic             sgn_q;
	logic [XS_W-1:0]  xa_q, xb_q, x_q;
	logic [YS_W-1:0]  ya_q, yb_q, y_q;
	logic signed [EW-1:0] a_q, b_q, c_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] clr_q;
	logic [1:0]        attr_q;
	logic [1:0]        step_q;
	logic signed [NUM_W-1:0] acc_q;
	logic              start_q;
	logic signed [DEPTH_W-1:0] z_q;
	logic [7:0]        r_q, g_q, bl_q;
	logic              out_valid_q;
	out_t              out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// active size saturated to the supported range
	always_comb begin
		w_eff = (w_raw_q == '0) ? CFG_W'(1) :
			(w_raw_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : w_raw_q;
		h_eff = (h_raw_q == '0) ? CFG_W'(1) :
			(h_raw_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : h_raw_q;
	end

	// fixed point to screen, truncating toward zero
	function automatic logic signed [SC_W-1:0] to_screen(input logic signed [16:0] t,
			input logic [CFG_W-1:0] n);
		logic signed [24:0] p;
		logic signed [24:0] adj;
		p   = t * $signed({1'b0, n});
		adj = p + (p[24] ? 25'sd16383 : 25'sd0);
		return adj[SC_W+13:14];
	endfunction

	// setup: doubled area and bounding box
	logic signed [SC_W:0] dx02, dx21, dy12, dy02;
	logic signed [22:0] den_raw;
	logic signed [SC_W-1:0] xmin, xmax, ymin, ymax;
	logic reject;
	always_comb begin
		dx02 = {sx_q[0][SC_W-1], sx_q[0]} - {sx_q[2][SC_W-1], sx_q[2]};
		dx21 = {sx_q[2][SC_W-1], sx_q[2]} - {sx_q[1][SC_W-1], sx_q[1]};
		dy12 = {sy_q[1][SC_W-1], sy_q[1]} - {sy_q[2][SC_W-1], sy_q[2]};
		dy02 = {sy_q[0][SC_W-1], sy_q[0]} - {sy_q[2][SC_W-1], sy_q[2]};
		den_raw = 23'(dy12 * dx02) + 23'(dx21 * dy02);
		xmin = (sx_q[0] < sx_q[1]) ? sx_q[0] : sx_q[1];
		xmin = (xmin < sx_q[2]) ? xmin : sx_q[2];
		xmax = (sx_q[0] > sx_q[1]) ? sx_q[0] : sx_q[1];
		xmax = (xmax > sx_q[2]) ? xmax : sx_q[2];
		ymin = (sy_q[0] < sy_q[1]) ? sy_q[0] : sy_q[1];
		ymin = (ymin < sy_q[2]) ? ymin : sy_q[2];
		ymax = (sy_q[0] > sy_q[1]) ? sy_q[0] : sy_q[1];
		ymax = (ymax > sy_q[2]) ? ymax : sy_q[2];
		reject = (xmin > $signed({3'b0, w_eff}) - SC_W'(1)) || xmax[SC_W-1] ||
			(ymin > $signed({3'b0, h_eff}) - SC_W'(1)) || ymax[SC_W-1];
	end

	// edge functions at the current pixel
	logic signed [SC_W:0] px_d, py_d, dy20, dx02b;
	logic signed [22:0] e1, e2;
	always_comb begin
		px_d  = $signed({{(SC_W+1-XS_W){1'b0}}, x_q}) - {sx_q[2][SC_W-1], sx_q[2]};
		py_d  = $signed({{(SC_W+1-YS_W){1'b0}}, y_q}) - {sy_q[2][SC_W-1], sy_q[2]};
		dy20  = {sy_q[2][SC_W-1], sy_q[2]} - {sy_q[0][SC_W-1], sy_q[0]};
		dx02b = {sx_q[0][SC_W-1], sx_q[0]} - {sx_q[2][SC_W-1], sx_q[2]};
		e1 = 23'(dy12 * px_d) + 23'(dx21 * py_d);
		e2 = 23'(dy20 * px_d) + 23'(dx02b * py_d);
	end

	// inside test and store index
	logic signed [EW-1:0] c_d;
	logic [12:0] idx_full;
	always_comb begin
		c_d = $signed({{(EW-DEN_W){1'b0}}, den_q}) - a_q - b_q;
		idx_full = 13'(y_q * w_eff) + 13'(x_q);
	end

	// weighted attribute product
	logic signed [EW-1:0] wsel;
	logic signed [24:0] asel;
	logic signed [NUM_W-1:0] prod;
	always_comb begin
		case (step_q)
			2'd0:    wsel = a_q;
			2'd1:    wsel = b_q;
			default: wsel = c_q;
		endcase
		case (attr_q)
			2'd0:    asel = {vz_q[step_q][23], vz_q[step_q]};
			2'd1:    asel = $signed({17'b0, vr_q[step_q]});
			2'd2:    asel = $signed({17'b0, vg_q[step_q]});
			default: asel = $signed({17'b0, vb_q[step_q]});
		endcase
		prod = NUM_W'(wsel * asel);
	end

	assign div_req.start = start_q;
	assign div_req.num   = acc_q;
	assign div_req.den   = den_q;

	trz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic accept;
	logic out_load;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_READ) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_raw_q <= CFG_W'(64);
			h_raw_q <= CFG_W'(64);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIDTH_IDX)
				w_raw_q <= cfg_data;
			else
				h_raw_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			vcount_q    <= '0;
			out_valid_q <= 1'b0;
			start_q     <= 1'b0;
			step_q      <= '0;
			attr_q      <= '0;
		end else begin
			start_q <= (state_q == S_MAC) && (step_q == 2'd2);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_INIT, S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_SIZE - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (in_data.operation)
							OP_VERTEX: begin
								if (vcount_q == 2'd2) begin
									vcount_q <= '0;
									state_q  <= S_MAP;
								end else begin
									vcount_q <= vcount_q + 1'b1;
								end
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							OP_READ: state_q <= S_READ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// hold the read until the result register is free
				S_READ: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				S_MAP: state_q <= S_SETUP;
				S_SETUP: begin
					if (den_raw == '0 || reject)
						state_q <= S_IDLE;
					else
						state_q <= S_EDGE;
				end
				S_EDGE: state_q <= S_TEST;
				S_TEST: begin
					if (a_q[EW-1] || b_q[EW-1] || c_d[EW-1]) begin
						state_q <= S_NEXT;
					end else begin
						attr_q  <= '0;
						step_q  <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (step_q == 2'd2) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (attr_q == 2'd0)
							state_q <= S_CMP;
						else if (attr_q == 2'd3)
							state_q <= S_WRITE;
						else begin
							attr_q  <= attr_q + 1'b1;
							state_q <= S_MAC;
						end
					end
				end
				S_CMP: begin
					if (z_q < depth_rd_q) begin
						attr_q  <= 2'd1;
						state_q <= S_MAC;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_WRITE: state_q <= S_NEXT;
				S_NEXT: state_q <= (x_q == xb_q && y_q == yb_q) ? S_IDLE : S_EDGE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && in_data.operation == OP_VERTEX) begin
			vx_q[vcount_q] <= in_data.vertex_x;
			vy_q[vcount_q] <= in_data.vertex_y;
			vz_q[vcount_q] <= in_data.vertex_depth;
			vr_q[vcount_q] <= in_data.vertex_red;
			vg_q[vcount_q] <= in_data.vertex_green;
			vb_q[vcount_q] <= in_data.vertex_blue;
		end
		if (state_q == S_MAP) begin
			for (int i = 0; i < 3; i++) begin
				sx_q[i] <= to_screen({vx_q[i][15], vx_q[i]} + 17'sd8192, w_eff);
				sy_q[i] <= to_screen(17'sd8192 - {vy_q[i][15], vy_q[i]}, h_eff);
			end
		end
		if (state_q == S_SETUP) begin
			sgn_q <= den_raw[22];
			den_q <= den_raw[22] ? DEN_W'(-den_raw) : DEN_W'(den_raw);
			xa_q  <= xmin[SC_W-1] ? '0 : XS_W'(xmin);
			ya_q  <= ymin[SC_W-1] ? '0 : YS_W'(ymin);
			xb_q  <= (xmax > $signed({3'b0, w_eff}) - SC_W'(1)) ?
				XS_W'(w_eff - 1'b1) : XS_W'(xmax);
			yb_q  <= (ymax > $signed({3'b0, h_eff}) - SC_W'(1)) ?
				YS_W'(h_eff - 1'b1) : YS_W'(ymax);
			x_q   <= xmin[SC_W-1] ? '0 : XS_W'(xmin);
			y_q   <= ymin[SC_W-1] ? '0 : YS_W'(ymin);
		end
		if (state_q == S_EDGE) begin
			a_q <= sgn_q ? -EW'(e1) : EW'(e1);
			b_q <= sgn_q ? -EW'(e2) : EW'(e2);
		end
		if (state_q == S_TEST) begin
			c_q   <= c_d;
			idx_q <= idx_full[ADDR_W-1:0];
		end
		if (state_q == S_MAC)
			acc_q <= (step_q == 2'd0) ? prod : acc_q + prod;
		if (state_q == S_DIV && div_rsp.done) begin
			case (attr_q)
				2'd0:    z_q  <= div_rsp.quo[DEPTH_W-1:0];
				2'd1:    r_q  <= div_rsp.quo[7:0];
				2'd2:    g_q  <= div_rsp.quo[7:0];
				default: bl_q <= div_rsp.quo[7:0];
			endcase
		end
		if (state_q == S_NEXT) begin
			if (x_q == xb_q) begin
				x_q <= xa_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (out_load) begin
			out_q.pixel_color <= color_rd_q;
			out_q.pixel_depth <= depth_rd_q;
		end
	end

	// store ports: one write and one registered read per cycle
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_depth, wr_color;
	logic [ADDR_W-1:0]   wr_addr;
	logic signed [DEPTH_W-1:0] wr_depth_data;
	logic [COLOR_W-1:0]  wr_color_data;
	always_comb begin
		rd_en   = (state_q == S_TEST) || (accept && in_data.operation == OP_READ);
		rd_addr = (state_q == S_TEST) ? idx_full[ADDR_W-1:0] :
			in_data.pixel_index[ADDR_W-1:0];
		wr_depth = (state_q == S_INIT) || (state_q == S_CLEAR) || (state_q == S_WRITE);
		wr_color = (state_q == S_INIT) || (state_q == S_WRITE);
		wr_addr  = (state_q == S_WRITE) ? idx_q : clr_q;
		wr_depth_data = (state_q == S_WRITE) ? z_q : DEPTH_MAX;
		wr_color_data = (state_q == S_WRITE) ? {r_q, g_q, bl_q} : '0;
	end

	always_ff @(posedge clk) begin
		if (wr_depth)
			depth_mem[wr_addr] <= wr_depth_data;
		if (rd_en)
			depth_rd_q <= depth_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_color)
			color_mem[wr_addr] <= wr_color_data;
		if (rd_en)
			color_rd_q <= color_mem[rd_addr];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// divider results arrive only while the sequencer waits for them
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider result outside divide wait");

	// a write-back only follows a passed depth test
	a_write_passed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |-> z_q < depth_rd_q)
		else $error("write-back without depth pass");

	// a result only appears after a read request
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_READ)
		else $error("result without read request");

	// no request is taken during a store sweep
	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT || state_q == S_CLEAR) |-> !in_ready)
		else $error("request taken during store sweep");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import trz_pkg::*;

	localparam int RUN_LIMIT_CYCLES = 2500000;

	typedef struct {
		longint x;
		longint y;
		longint z;
		longint r;
		longint g;
		longint b;
	} vtx_t;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t pix;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_WIDTH_IDX;
	logic [CFG_W-1:0] cfg_data = '0;

	// screen model state
	logic signed [23:0] depth_mem [STORE_SIZE];
	logic [23:0]        color_mem [STORE_SIZE];
	vtx_t               held_vtx [2];
	int unsigned        held_count;
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;

	out_t pending_pixels [$];
	row_t stim_rows [$];
	int   errors = 0;
	int   snd_idle = 9;
	int   rcv_idle = 54;

	triangle_raster_zbuffer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#(RUN_LIMIT_CYCLES * 4);
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rasterize one triangle into the model stores
	task automatic raster_triangle(input vtx_t v0, input vtx_t v1, input vtx_t v2);
		longint w, h, x0, x1, x2, y0, y1, y2, den, sgn;
		longint xa, xb, ya, yb, mnx, mxx, mny, mxy, a, b, c, z, idx;
		w = clamp(width_reg, 1, MAX_WIDTH);
		h = clamp(height_reg, 1, MAX_HEIGHT);
		x0 = (v0.x + 8192) * w / 16384;
		x1 = (v1.x + 8192) * w / 16384;
		x2 = (v2.x + 8192) * w / 16384;
		y0 = (8192 - v0.y) * h / 16384;
		y1 = (8192 - v1.y) * h / 16384;
		y2 = (8192 - v2.y) * h / 16384;
		den = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
		if (den == 0) return;
		sgn = 1;
		if (den < 0) begin
			sgn = -1;
			den = -den;
		end
		mnx = x0 < x1 ? x0 : x1; mnx = mnx < x2 ? mnx : x2;
		mxx = x0 > x1 ? x0 : x1; mxx = mxx > x2 ? mxx : x2;
		mny = y0 < y1 ? y0 : y1; mny = mny < y2 ? mny : y2;
		mxy = y0 > y1 ? y0 : y1; mxy = mxy > y2 ? mxy : y2;
		if (mnx > w - 1 || mxx < 0 || mny > h - 1 || mxy < 0) return;
		xa = clamp(mnx, 0, w - 1);
		xb = clamp(mxx, 0, w - 1);
		ya = clamp(mny, 0, h - 1);
		yb = clamp(mxy, 0, h - 1);
		for (longint y = ya; y <= yb; y++) begin
			for (longint x = xa; x <= xb; x++) begin
				a = sgn * ((y1 - y2) * (x - x2) + (x2 - x1) * (y - y2));
				b = sgn * ((y2 - y0) * (x - x2) + (x0 - x2) * (y - y2));
				c = den - a - b;
				if (a < 0 || b < 0 || c < 0) continue;
				z = (a * v0.z + b * v1.z + c * v2.z) / den;
				idx = y * w + x;
				if (idx < 0 || idx >= STORE_SIZE) continue;
				if (z < longint'(depth_mem[idx])) begin
					depth_mem[idx] = z[23:0];
					color_mem[idx] = {8'((a * v0.r + b * v1.r + c * v2.r) / den),
						8'((a * v0.g + b * v1.g + c * v2.g) / den),
						8'((a * v0.b + b * v1.b + c * v2.b) / den)};
				end
			end
		end
	endtask

	// apply one request to the model; returns 1 when a pixel comes back
	task automatic model_request(input in_t r, output bit has_pix, output out_t pix);
		vtx_t v;
		has_pix = 1'b0;
		pix = '0;
		case (r.operation)
			OP_VERTEX: begin
				v.x = r.vertex_x;
				v.y = r.vertex_y;
				v.z = r.vertex_depth;
				v.r = r.vertex_red;
				v.g = r.vertex_green;
				v.b = r.vertex_blue;
				if (held_count >= 2) begin
					raster_triangle(held_vtx[0], held_vtx[1], v);
					held_count = 0;
				end else begin
					held_vtx[held_count] = v;
					held_count++;
				end
			end
			OP_CLEAR: begin
				foreach (depth_mem[i]) depth_mem[i] = DEPTH_MAX;
			end
			OP_READ: begin
				has_pix = 1'b1;
				pix.pixel_color = color_mem[r.pixel_index];
				pix.pixel_depth = depth_mem[r.pixel_index];
			end
			default: ;
		endcase
	endtask

	// drive one request and wait for its acceptance
	task automatic send_request(input in_t r, input bit typed, input out_t typed_pix);
		bit   has_pix;
		out_t pix;
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = r;
		do @(posedge clk); while (!in_ready);
		model_request(r, has_pix, pix);
		if (has_pix) pending_pixels.push_back(typed ? typed_pix : pix);
	endtask

	// read request as a barrier: the block takes one request at a time
	task automatic drain_block();
		in_t r;
		r = '0;
		r.operation = OP_READ;
		r.pixel_index = 12'($urandom_range(0, 4095));
		send_request(r, 1'b0, '0);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_WIDTH_IDX) width_reg = val;
		else height_reg = val;
	endtask

	function automatic in_t make_req(input logic [1:0] op, input int x, input int y,
			input int z, input int r, input int g, input int b, input int idx);
		in_t q;
		q.operation = op;
		q.vertex_x = 16'(x);
		q.vertex_y = 16'(y);
		q.vertex_depth = 24'(z);
		q.vertex_red = 8'(r);
		q.vertex_green = 8'(g);
		q.vertex_blue = 8'(b);
		q.pixel_index = 12'(idx);
		return q;
	endfunction

	function automatic row_t make_row(input in_t q, input bit typed, input out_t pix);
		row_t row;
		row.req = q;
		row.typed = typed;
		row.pix = pix;
		return row;
	endfunction

	// random requests; wide mode spreads positions over the whole field range
	task automatic random_requests(input int count, input bit wide);
		in_t q;
		int  sel, cx, cy, span;
		cx = 0;
		cy = 0;
		for (int n = 0; n < count; n++) begin
			q = make_req(OP_VERTEX, 0, 0, 0, 0, 0, 0, 0);
			{q.vertex_depth, q.vertex_red, q.vertex_green, q.vertex_blue} = 48'({$urandom, $urandom});
			span = clamp(width_reg, 1, MAX_WIDTH) * clamp(height_reg, 1, MAX_HEIGHT);
			q.pixel_index = 12'($urandom_range(0, span - 1));
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				if (wide) begin
					q.vertex_x = 16'($urandom);
					q.vertex_y = 16'($urandom);
				end else begin
					if (held_count == 0) begin
						cx = $urandom_range(0, 14000) - 7000;
						cy = $urandom_range(0, 14000) - 7000;
					end
					q.vertex_x = 16'(cx + $urandom_range(0, 1200) - 600);
					q.vertex_y = 16'(cy + $urandom_range(0, 1200) - 600);
				end
			end else if (sel < 92) begin
				q.operation = OP_READ;
				if ($urandom_range(0, 3) == 0) q.pixel_index = 12'($urandom);
			end else if (sel < 96) begin
				q.operation = OP_CLEAR;
			end else begin
				q.operation = 2'd3;
			end
			send_request(q, 1'b0, '0);
		end
	endtask

	// result side: random stall per cycle, check on every accepted pixel
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel", out_data, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.pixel_color !== want.pixel_color)
					report_mismatch("pixel_color", out_data.pixel_color, want.pixel_color);
				if (out_data.pixel_depth !== want.pixel_depth)
					report_mismatch("pixel_depth", out_data.pixel_depth, want.pixel_depth);
			end
		end
	end

	initial begin
		out_t blank;
		blank.pixel_color = '0;
		blank.pixel_depth = DEPTH_MAX;
		foreach (depth_mem[i]) begin
			depth_mem[i] = DEPTH_MAX;
			color_mem[i] = '0;
		end
		held_count = 0;
		held_vtx[0] = '{0, 0, 0, 0, 0, 0};
		held_vtx[1] = '{0, 0, 0, 0, 0, 0};
		width_reg = 7'd64;
		height_reg = 7'd64;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed part on a 4 by 4 screen
		write_reg(CFG_WIDTH_IDX, 7'd4);
		write_reg(CFG_HEIGHT_IDX, 7'd4);
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 4095), 1, blank));
		stim_rows.push_back(make_row(make_req(2'd3, -1, -1, -1, 255, 255, 255, 4095), 0, blank));
		// triangle from the coordinate extremes, covering the upper-left part of the screen
		stim_rows.push_back(make_row(make_req(OP_VERTEX, -32768, 32767, -8388608, 255, 0, 255, 0),
			0, blank));
		stim_rows.push_back(make_row(make_req(OP_VERTEX, 32767, 32767, 0, 0, 255, 0, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_VERTEX, -32768, -32768, 8388607, 255, 255, 255, 0),
			0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 5), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 15), 0, blank));
		// degenerate triangle draws nothing
		for (int i = 0; i < 3; i++)
			stim_rows.push_back(make_row(make_req(OP_VERTEX, 0, 0, -100, 9, 9, 9, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 10), 0, blank));
		// clear keeps colors
		stim_rows.push_back(make_row(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 5), 0, blank));
		// triangle at maximum depth never passes
		stim_rows.push_back(make_row(make_req(OP_VERTEX, -8192, 8192, 8388607, 1, 2, 3, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_VERTEX, 8191, 8192, 8388607, 1, 2, 3, 0), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_VERTEX, 0, -8192, 8388607, 1, 2, 3, 0), 0, blank));
		// triangle wholly off screen to the right
		for (int i = 0; i < 3; i++)
			stim_rows.push_back(make_row(make_req(OP_VERTEX, 32767, 1000 * i, -5, 7, 7, 7, 0),
				0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 3), 0, blank));
		stim_rows.push_back(make_row(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 4095), 1, blank));
		foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].pix);
		drain_block();

		// full screen, small triangles
		write_reg(CFG_WIDTH_IDX, 7'd64);
		write_reg(CFG_HEIGHT_IDX, 7'd64);
		random_requests(38, 1'b0);
		drain_block();

		// saturating sizes: width 0 and height 127
		snd_idle = 54;
		rcv_idle = 9;
		write_reg(CFG_WIDTH_IDX, 7'd0);
		write_reg(CFG_HEIGHT_IDX, 7'd127);
		random_requests(38, 1'b1);
		drain_block();

		// odd small screen, no idling
		snd_idle = 0;
		rcv_idle = 0;
		write_reg(CFG_WIDTH_IDX, 7'd7);
		write_reg(CFG_HEIGHT_IDX, 7'd5);
		random_requests(38, 1'b1);
		drain_block();
		repeat (50) @(negedge clk);

		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
